[hdl/spgb_pkg.sv]
// shared types, constants and helpers for the slab particle grid binner
`default_nettype none
package spgb_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam int POS_BITS_DEF  = 24;

  localparam int SUM48_W = 48;
  localparam int SUM64_W = 64;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVV  = 2'd2;

  localparam logic [1:0] MODE_DARK = 2'd0;
  localparam logic [1:0] MODE_GAS  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [SUM48_W-1:0] MAX48 = {SUM48_W{1'b1}};
  localparam logic [SUM64_W-1:0] MAX64 = {SUM64_W{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR,   // post-reset sweep zeroing the cell memory
    ST_IDLE,    // waiting for an input transfer
    ST_RD,      // memory read issued
    ST_UPD,     // accumulate and write back
    ST_MUL,     // density partial products
    ST_MUL2,    // density sum and saturation
    ST_DIV,     // shared divider running
    ST_OUT      // result held until the receiver takes it
  } spgb_state_t;

  typedef struct packed {
    logic clr_step;   // write zero at sweep address, advance
    logic load;       // capture input item
    logic rd;         // read memory at item address
    logic upd;        // write accumulated entry
    logic mul;        // first density stage
    logic mul2;       // second density stage
    logic div_start;  // start divider on current operand
    logic out_load;   // build the result word
  } spgb_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_read;    // item is a mode 2 read-out
    logic is_bin;     // item updates a cell
    logic div_done;
    logic div_last;   // second division finished
  } spgb_sts_t;

endpackage
`default_nettype wire

[hdl/spgb_datapath.sv]
// datapath: cell memory, accumulators, density multiply and mean divider
`default_nettype none
module spgb_datapath #(
  parameter int GRID_SIZE = spgb_pkg::GRID_SIZE_DEF,
  parameter int POS_BITS  = spgb_pkg::POS_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire spgb_pkg::spgb_cmd_t       cmd,
  output spgb_pkg::spgb_sts_t            sts,
  input  wire logic [1:0]                in_mode,
  input  wire logic [23:0]               in_pos_x,
  input  wire logic [23:0]               in_pos_y,
  input  wire logic [23:0]               in_pos_z,
  input  wire logic [31:0]               in_gas_mass,
  input  wire logic [31:0]               in_temperature,
  input  wire logic [15:0]               in_neutral_fraction,
  input  wire logic [7:0]                in_read_x,
  input  wire logic [7:0]                in_read_y,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_wdata,
  output logic [159:0]                   res_data
);
  import spgb_pkg::*;

  localparam int GB = $clog2(GRID_SIZE);
  localparam int AW = 2 * GB;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int ENT_W = 3 * SUM48_W + SUM64_W;

  // configuration
  logic [23:0] slice_r;
  logic [31:0] dmass_r, invv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= 24'h800000;
      dmass_r <= 32'd1;
      invv_r  <= 32'h10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLICE: slice_r <= cfg_wdata[23:0];
        CFG_DMASS: dmass_r <= cfg_wdata;
        CFG_INVV:  invv_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // positions modulo the box
  function automatic logic [POS_BITS-1:0] pos_w(input logic [23:0] p);
    logic [POS_BITS+23:0] e;
    e = {{POS_BITS{1'b0}}, p};
    return e[POS_BITS-1:0];
  endfunction

  logic [POS_BITS-1:0] px, py, pz, ps;
  logic [POS_BITS:0]   dz;
  logic [POS_BITS+GB+1:0] dz2;
  logic in_slab;
  always_comb begin
    px = pos_w(in_pos_x);
    py = pos_w(in_pos_y);
    pz = pos_w(in_pos_z);
    ps = pos_w(slice_r);
    dz = (pz >= ps) ? {1'b0, pz - ps} : {1'b0, ps - pz};
    dz2 = {{(GB+1){1'b0}}, dz} << (GB + 1);
    in_slab = dz2 < ({{(GB+1){1'b0}}, 1'b1, {POS_BITS{1'b0}}});
  end

  // grid size is a power of two: cell index is the top bits
  logic [GB-1:0] ix, iy;
  assign ix = px[POS_BITS-1 -: GB];
  assign iy = py[POS_BITS-1 -: GB];

  logic read_in_grid;
  logic [15:0] rx_w, ry_w;
  assign rx_w = {8'd0, in_read_x};
  assign ry_w = {8'd0, in_read_y};
  assign read_in_grid = (rx_w < 16'(GRID_SIZE)) && (ry_w < 16'(GRID_SIZE));

  // captured item
  logic [1:0] mode_r;
  logic [AW-1:0] addr_r;
  logic valid_r;  // bin in slab, or read in grid
  logic [7:0] rx_r, ry_r;
  logic [31:0] m_r, t_r;
  logic [15:0] f_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      rx_r <= in_read_x;
      ry_r <= in_read_y;
      m_r <= in_gas_mass;
      t_r <= in_temperature;
      f_r <= in_neutral_fraction;
      if (in_mode == MODE_READ) begin
        addr_r  <= {in_read_x[GB-1:0], in_read_y[GB-1:0]};
        valid_r <= read_in_grid;
      end else begin
        addr_r  <= {ix, iy};
        valid_r <= in_slab;
      end
    end
  end
  assign sts.is_read = (in_mode == MODE_READ);
  assign sts.is_bin  = (in_mode == MODE_DARK || in_mode == MODE_GAS) && in_slab;

  // cell memory {dark, gas, temp, neutral}
  logic [ENT_W-1:0] mem [CELLS];
  logic [ENT_W-1:0] rd_r;
  logic [AW:0] clr_r;
  logic        we;
  logic [AW-1:0] wa;
  logic [ENT_W-1:0] wd;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd) rd_r <= mem[addr_r];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end
  assign sts.clr_done = clr_r[AW];

  logic [47:0] e_dark, e_gas, e_neu;
  logic [63:0] e_tmp;
  assign {e_dark, e_gas, e_tmp, e_neu} = rd_r;

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  // products registered one stage before update
  logic [63:0] tm_r;
  logic [47:0] fm_r;
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      tm_r <= t_r * m_r;
      fm_r <= 48'(f_r) * 48'(m_r);
    end
  end
  logic [64:0] ts;
  always_comb begin
    ts = {1'b0, e_tmp} + {1'b0, tm_r};
    we = 1'b0;
    wa = addr_r;
    wd = rd_r;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_r[AW-1:0];
      wd = '0;
    end else if (cmd.upd && valid_r) begin
      we = 1'b1;
      if (mode_r == MODE_DARK)
        wd = {sat48(e_dark, {16'd0, dmass_r}), e_gas, e_tmp, e_neu};
      else if (mode_r == MODE_GAS)
        wd = {e_dark, sat48(e_gas, {16'd0, m_r}), ts[64] ? MAX64 : ts[63:0],
              sat48(e_neu, fm_r)};
      else
        wd = '0;  // read-out clears the cell
    end
  end

  // density: sum * hi and sum * lo in one stage, combine in the next
  logic [63:0] dhi_r, ghi_r, dlo_r, glo_r;
  logic [47:0] dd_r, gd_r;
  function automatic logic [47:0] dens(input logic [63:0] hi, input logic [63:0] lo);
    logic [64:0] s;
    s = {1'b0, hi} + {17'd0, lo[63:16]};
    return (s[64:48] != 0) ? MAX48 : s[47:0];
  endfunction
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dhi_r <= e_dark * invv_r[31:16];
      ghi_r <= e_gas * invv_r[31:16];
      dlo_r <= e_dark * invv_r[15:0];
      glo_r <= e_gas * invv_r[15:0];
    end
    if (cmd.mul2) begin
      dd_r <= dens(dhi_r, dlo_r);
      gd_r <= dens(ghi_r, glo_r);
    end
  end

  // shared restoring divider, one quotient bit a cycle, two runs
  logic [63:0] q_r;
  logic [48:0] rm_r;
  logic [6:0]  cnt_r;
  logic        second_r, busy_r;
  logic [31:0] mt_r;
  logic [15:0] mf_r;
  logic [49:0] trial;
  assign trial = {rm_r, q_r[63]} - {2'b0, e_gas};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      second_r <= 1'b0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      rm_r   <= '0;
      q_r    <= second_r ? {16'd0, e_neu} : e_tmp;
    end else if (busy_r) begin
      if (trial[49]) begin
        rm_r <= {rm_r[47:0], q_r[63]};
        q_r  <= {q_r[62:0], 1'b0};
      end else begin
        rm_r <= trial[48:0];
        q_r  <= {q_r[62:0], 1'b1};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        second_r <= !second_r;
      end
    end
  end
  assign sts.div_done = !busy_r;
  assign sts.div_last = !second_r;
  always_ff @(posedge clk) begin
    if (!busy_r && cmd.div_start && !second_r) mt_r <= 32'd0;
    if (busy_r && cnt_r == 7'd1) begin
      if (second_r) mf_r <= (q_r[62:15] != 0) ? 16'hFFFF : {q_r[14:0], !trial[49]};
      else mt_r <= (q_r[62:31] != 0) ? 32'hFFFFFFFF : {q_r[30:0], !trial[49]};
    end
  end

  logic gz;
  assign gz = (e_gas == 0) || !valid_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load)
      res_data <= {gz ? 16'd0 : mf_r, gz ? 32'd0 : mt_r,
                   valid_r ? gd_r : 48'd0, valid_r ? dd_r : 48'd0, ry_r, rx_r};
  end
endmodule
`default_nettype wire

[hdl/spgb_ctrl.sv]
// controller state machine sequencing bin updates and read-outs
`default_nettype none
module spgb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire spgb_pkg::spgb_sts_t  sts,
  output spgb_pkg::spgb_cmd_t       cmd
);
  import spgb_pkg::*;

  spgb_state_t st_r, st_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_CLEAR;
    else st_r <= st_nxt;
  end

  logic rd_is_read_r, rd_is_read_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_is_read_r <= 1'b0;
    else rd_is_read_r <= rd_is_read_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    rd_is_read_nxt = rd_is_read_r;
    case (st_r)
      ST_CLEAR: begin
        if (sts.clr_done) st_nxt = ST_IDLE;
        else cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          rd_is_read_nxt = sts.is_read;
          if (sts.is_read || sts.is_bin) st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        st_nxt = rd_is_read_r ? ST_MUL : ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.div_start = 1'b1;
        st_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (sts.div_last) begin
            cmd.out_load = 1'b1;
            cmd.upd = 1'b1;
            st_nxt = ST_OUT;
          end else cmd.div_start = 1'b1;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hdl/slab_particle_grid_binner.sv]
// top level of the slab particle grid binner
// Usage: input items arrive on the in_ stream, one transfer per item; mode 0
// adds a dark particle, mode 1 a gas cell, mode 2 reads out and clears one
// cell. Only mode 2 produces a result transfer on the out_ stream.
// Bin items pass through accept, memory read and write-back; items that bin
// nothing are only accepted. A read-out passes through the memory read, two
// density multiply stages and two 64-step runs of one shared restoring
// divider (mean temperature, mean neutral fraction), the first run starting
// with the first multiply stage, before its result is presented; with
// out_tready high, the next item is taken once it is transferred.
// After reset all GRID_SIZE*GRID_SIZE cells of the memory (65536 at the default)
// are swept to zero, with in_tready low; config writes still land.
// The result stays in the output register while out_tready is low and no
// new item is taken until it is transferred.
// Config writes are one cycle: cfg_we, cfg_index, cfg_wdata.
`default_nettype none
module slab_particle_grid_binner #(
  parameter int GRID_SIZE = spgb_pkg::GRID_SIZE_DEF,
  parameter int POS_BITS  = spgb_pkg::POS_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode, pos_x, pos_y, pos_z, gas_mass, temperature, neutral_fraction,
  // read_x, read_y from bit 0 up, zero padded
  input  wire logic [175:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // cell_x, cell_y, dark_density, gas_density, mean_temperature,
  // mean_neutral_fraction from bit 0 up
  output logic [159:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import spgb_pkg::*;

  spgb_cmd_t cmd;
  spgb_sts_t sts;

  spgb_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd
  );

  spgb_datapath #(.GRID_SIZE(GRID_SIZE), .POS_BITS(POS_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode(in_tdata[1:0]),
    .in_pos_x(in_tdata[25:2]),
    .in_pos_y(in_tdata[49:26]),
    .in_pos_z(in_tdata[73:50]),
    .in_gas_mass(in_tdata[105:74]),
    .in_temperature(in_tdata[137:106]),
    .in_neutral_fraction(in_tdata[153:138]),
    .in_read_x(in_tdata[161:154]),
    .in_read_y(in_tdata[169:162]),
    .cfg_we, .cfg_index, .cfg_wdata,
    .res_data(out_tdata)
  );
endmodule
`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the slab particle grid binner
`timescale 1ns / 1ps
module tb;
  import spgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int MODE_UNUSED = 3;

  typedef struct {
    logic [1:0]  mode;
    logic [23:0] pos_x, pos_y, pos_z;
    logic [31:0] gas_mass, temperature;
    logic [15:0] neutral_fraction;
    logic [7:0]  read_x, read_y;
  } particle_t;

  typedef struct {
    logic [7:0]  cell_x, cell_y;
    logic [47:0] dark_density, gas_density;
    logic [31:0] mean_temperature;
    logic [15:0] mean_neutral_fraction;
  } cell_readout_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [175:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [159:0] out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  slab_particle_grid_binner dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predicted block state
  logic [23:0] slab_center;
  logic [31:0] dark_mass, inv_volume;
  logic [47:0] dark_sum[int];
  logic [47:0] gas_sum[int];
  logic [63:0] temp_sum[int];
  logic [47:0] neutral_sum[int];

  cell_readout_t expected_readouts[$];
  int mismatches = 0;
  int readouts_seen = 0;
  int items_sent = 0;
  int binned = 0;
  int quiet_cycles = 0;
  bit sink_stalls = 1;
  bit src_gaps = 1;
  logic [7:0] hot_x[4], hot_y[4];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [64:0] s;
    if (a > lim) a = lim;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, lim}) ? lim : s[63:0];
  endfunction

  function automatic logic [47:0] scale_density(logic [47:0] s);
    logic [95:0] p;
    p = (s * {64'd0, inv_volume}) >> 16;
    return (p > {48'd0, MAX48}) ? MAX48 : p[47:0];
  endfunction

  function automatic logic [63:0] weighted_mean(logic [63:0] w, logic [47:0] m,
                                                logic [63:0] lim);
    logic [63:0] q;
    if (m == 0) return 0;
    q = w / m;
    return (q > lim) ? lim : q;
  endfunction

  // update the predicted grid for one accepted item
  task automatic bin_or_read(particle_t p);
    logic [23:0] dz;
    int a;
    cell_readout_t r;
    case (p.mode)
      MODE_DARK, MODE_GAS: begin
        dz = (p.pos_z >= slab_center) ? p.pos_z - slab_center : slab_center - p.pos_z;
        if (dz < 24'd32768) begin
          binned++;
          a = int'({p.pos_x[23:16], p.pos_y[23:16]});
          if (!dark_sum.exists(a)) begin
            dark_sum[a] = 0; gas_sum[a] = 0; temp_sum[a] = 0; neutral_sum[a] = 0;
          end
          if (p.mode == MODE_DARK) begin
            dark_sum[a] = 48'(sat_add(dark_sum[a], dark_mass, MAX48));
          end else begin
            gas_sum[a] = 48'(sat_add(gas_sum[a], p.gas_mass, MAX48));
            temp_sum[a] = sat_add(temp_sum[a], p.temperature * 64'(p.gas_mass), MAX64);
            neutral_sum[a] = 48'(sat_add(neutral_sum[a],
                                         p.neutral_fraction * 64'(p.gas_mass), MAX48));
          end
        end
      end
      MODE_READ: begin
        a = int'({p.read_x, p.read_y});
        r = '{p.read_x, p.read_y, 0, 0, 0, 0};
        if (dark_sum.exists(a)) begin
          r.dark_density = scale_density(dark_sum[a]);
          r.gas_density = scale_density(gas_sum[a]);
          r.mean_temperature = 32'(weighted_mean(temp_sum[a], gas_sum[a], 64'hFFFF_FFFF));
          r.mean_neutral_fraction = 16'(weighted_mean(neutral_sum[a], gas_sum[a],
                                                      64'hFFFF));
          dark_sum.delete(a); gas_sum.delete(a); temp_sum.delete(a); neutral_sum.delete(a);
        end
        expected_readouts.push_back(r);
      end
      default: ;  // unused mode is dropped
    endcase
  endtask

  // one item on the input stream, predicted at its transfer
  task automatic send_item(particle_t p);
    @(negedge clk);
    in_tvalid = 1;
    in_tdata = '0;
    in_tdata[169:0] = {p.read_y, p.read_x, p.neutral_fraction, p.temperature,
                       p.gas_mass, p.pos_z, p.pos_y, p.pos_x, p.mode};
    do @(posedge clk); while (!in_tready);
    bin_or_read(p);
    items_sent++;
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_tvalid = 0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait for all readouts, then for any bin item still in flight
  task automatic drain();
    idle_input(1);
    while (expected_readouts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_tvalid = 0;
    cfg_we = 1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_SLICE: slab_center = val[23:0];
      CFG_DMASS: dark_mass = val;
      CFG_INVV:  inv_volume = val;
      default: ;
    endcase
  endtask

  function automatic particle_t make_bin(logic [1:0] mode, logic [23:0] x, logic [23:0] y,
                                         logic [23:0] z);
    particle_t p;
    p = '{mode, x, y, z, $urandom, $urandom, 16'($urandom), 8'($urandom), 8'($urandom)};
    return p;
  endfunction

  function automatic particle_t make_read(logic [7:0] cx, logic [7:0] cy);
    particle_t p;
    p = make_bin(MODE_READ, 24'($urandom), 24'($urandom), 24'($urandom));
    p.read_x = cx; p.read_y = cy;
    return p;
  endfunction

  // corners, slab edges, saturation, unused mode, empty and cleared cells
  task automatic test_directed();
    particle_t p;
    send_item(make_bin(MODE_DARK, 24'h000000, 24'h000000, 24'h800000));
    send_item(make_bin(MODE_DARK, 24'hFFFFFF, 24'hFFFFFF, 24'h800000 + 24'd32767));
    send_item(make_bin(MODE_DARK, 24'hFFFFFF, 24'hFFFFFF, 24'h800000 - 24'd32767));
    send_item(make_bin(MODE_DARK, 24'hFFFFFF, 24'hFFFFFF, 24'h800000 + 24'd32768));
    send_item(make_bin(MODE_DARK, 24'hFFFFFF, 24'hFFFFFF, 24'h800000 - 24'd32768));
    p = make_bin(MODE_GAS, 24'h12_3456, 24'h34_5678, 24'h800000);
    p.gas_mass = '1; p.temperature = '1; p.neutral_fraction = '1;
    send_item(p);
    send_item(p);   // weighted sums saturate
    p.mode = 2'(MODE_UNUSED);
    send_item(p);
    send_item(make_bin(2'(MODE_UNUSED), 24'h000000, 24'h000000, 24'h800000));
    p = make_bin(MODE_GAS, 24'h12_0000, 24'h34_0000, 24'h800000);
    p.gas_mass = 0;
    send_item(p);
    send_item(make_read(8'h00, 8'h00));
    send_item(make_read(8'hFF, 8'hFF));
    send_item(make_read(8'h12, 8'h34));
    send_item(make_read(8'h12, 8'h34));   // already cleared
    send_item(make_read(8'h55, 8'hAA));   // never touched
    drain();
  endtask

  // dark mass and density scale extremes, with the slab centre at either end of the box
  task automatic test_register_extremes();
    particle_t p;
    write_reg(CFG_SLICE, 32'h00FF_FFFF);
    write_reg(CFG_DMASS, 32'hFFFF_FFFF);
    write_reg(CFG_INVV, 32'hFFFF_FFFF);
    repeat (4) send_item(make_bin(MODE_DARK, 24'h7F_0000, 24'h80_0000, 24'hFF_FFFF));
    p = make_bin(MODE_GAS, 24'h7F_0000, 24'h80_0000, 24'hFF_8001);
    p.gas_mass = '1;
    send_item(p);
    send_item(make_read(8'h7F, 8'h80));
    drain();
    write_reg(CFG_SLICE, 32'h0000_0000);
    write_reg(CFG_DMASS, 32'h0000_0000);
    write_reg(CFG_INVV, 32'h0000_0000);
    send_item(make_bin(MODE_DARK, 24'h01_0000, 24'h02_0000, 24'h00_7FFF));
    p = make_bin(MODE_GAS, 24'h01_0000, 24'h02_0000, 24'h00_0000);
    send_item(p);
    send_item(make_read(8'h01, 8'h02));
    drain();
  endtask

  // mostly in-slab items on a few busy cells, read out regularly
  task automatic test_random(int count);
    particle_t p;
    int k, c;
    for (k = 0; k < 4; k++) begin
      hot_x[k] = 8'($urandom); hot_y[k] = 8'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(0, 3);
      k = $urandom_range(0, 99);
      if (k < 35) begin
        p = make_bin(MODE_DARK, {hot_x[c], 16'($urandom)}, {hot_y[c], 16'($urandom)},
                     slab_center + 24'($urandom_range(0, 65534)) - 24'd32767);
      end else if (k < 70) begin
        p = make_bin(MODE_GAS, {hot_x[c], 16'($urandom)}, {hot_y[c], 16'($urandom)},
                     slab_center + 24'($urandom_range(0, 65534)) - 24'd32767);
        if ($urandom_range(0, 3) == 0) p.gas_mass = 32'($urandom_range(0, 255));
      end else if (k < 78) begin
        p = make_bin(2'($urandom_range(0, 1)), 24'($urandom), 24'($urandom), 24'($urandom));
      end else if (k < 96) begin
        p = make_read(hot_x[c], hot_y[c]);
        if ($urandom_range(0, 5) == 0) p = make_read(8'($urandom), 8'($urandom));
      end else begin
        p = make_bin(2'(MODE_UNUSED), 24'($urandom), 24'($urandom), 24'($urandom));
      end
      if (src_gaps && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 13));
      if (src_gaps && $urandom_range(0, 150) == 0) drain();   // full back-off
      send_item(p);
    end
    for (k = 0; k < 4; k++) send_item(make_read(hot_x[k], hot_y[k]));
    drain();
  endtask

  // receiver stalls in bursts
  initial begin
    out_tready = 1;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_tready = 0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cell_readout_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[63:16], out_tdata[111:64],
              out_tdata[143:112], out_tdata[159:144]};
      readouts_seen++;
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected readout %p", got);
      end else begin
        want = expected_readouts.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("readout mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer (covers the post-reset sweep)
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    slab_center = 24'h800000; dark_mass = 1; inv_volume = 32'h10000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_register_extremes();
    write_reg(CFG_SLICE, 32'h0040_0000);
    write_reg(CFG_DMASS, 32'h0001_2345);
    write_reg(CFG_INVV, 32'h0003_8000);
    test_random(450);
    write_reg(CFG_SLICE, 32'h00FF_FFFF);
    write_reg(CFG_DMASS, 32'hFFFF_FFFF);
    write_reg(CFG_INVV, 32'h0000_0001);
    test_random(250);
    sink_stalls = 0;
    src_gaps = 0;
    write_reg(CFG_SLICE, 32'h0000_0000);
    write_reg(CFG_DMASS, 32'h0000_0007);
    write_reg(CFG_INVV, 32'h0001_0000);
    test_random(250);
    repeat (200) @(posedge clk);
    $display("sent %0d items, %0d binned into the slab, %0d cell readouts checked",
             items_sent, binned, readouts_seen);
    $display("covered slab edges, saturation, empty cells and five register settings");
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d readouts missing", mismatches, expected_readouts.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/spgb_pkg.sv
hdl/spgb_datapath.sv
hdl/spgb_ctrl.sv
hdl/slab_particle_grid_binner.sv
sim/tb.sv
